// ===== rtl/cht_pkg.sv =====
package cht_pkg;

    localparam int BUCKETS_DEF = 16;
    localparam int NODES_DEF = 64;

    localparam int REQ_W = 2;
    localparam int KEY_W = 31;
    localparam int AGE_W = 8;
    localparam int ST_W = 3;
    localparam int NB_W = 5;
    localparam int REM_W = NB_W + 1;
    localparam int CNT_W = 5;

    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [NB_W-1:0] NB_RESET = 5'd10;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_DELETED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL = 3'd4;

    localparam logic REG_NUM_BUCKETS = 1'b0;

    typedef struct packed {
        logic push;
        logic pop;
    } free_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } free_stat_t;

endpackage

// ===== rtl/cht_mod.sv =====
module cht_mod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cht_pkg::KEY_W-1:0]   dividend,
    input  logic [cht_pkg::NB_W-1:0]    divisor,
    output logic                        done,
    output logic [cht_pkg::REM_W-1:0]   rem
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [cht_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cht_pkg::KEY_W-1:0]  dvd_reg, dvd_next;
    logic [cht_pkg::NB_W-1:0]   div_reg, div_next;
    logic [cht_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [cht_pkg::REM_W-1:0]  rem_shift;
    logic [cht_pkg::REM_W-1:0]  div_ext;

    // One restoring step per cycle: shift in one dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg[cht_pkg::NB_W-1:0], dvd_reg[cht_pkg::KEY_W-1]};
    assign div_ext = {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[cht_pkg::KEY_W-2:0], 1'b0};
            rem_next = (rem_shift >= div_ext) ? (rem_shift - div_ext) : rem_shift;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cht_pkg::CNT_W'(cht_pkg::KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem = rem_reg;

endmodule

// ===== rtl/cht_free.sv =====
module cht_free
#(
    parameter int NODES = cht_pkg::NODES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cht_pkg::free_ctl_t          ctl,
    input  logic [$clog2(NODES)-1:0]    push_node,
    output cht_pkg::free_stat_t         stat,
    output logic [$clog2(NODES)-1:0]    top_node
);

    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);

    logic [NW-1:0] stack_mem [NODES];
    logic [PW-1:0] count_reg, count_next;
    logic [PW-1:0] low_reg, low_next;
    logic [NW-1:0] top_idx;
    logic [NW-1:0] rd_q;
    logic          below_low;

    // Entries below the lowest count reached are unwritten; their node is implied.
    assign top_idx = NW'(count_reg - 1'b1);
    assign below_low = (PW'(top_idx) < low_reg);
    assign top_node = below_low ? (NW'(NODES - 1) - top_idx) : rd_q;

    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg >= PW'(NODES));

    always_comb
    begin
        count_next = count_reg;
        low_next = low_reg;
        if (ctl.pop && !stat.empty)
        begin
            count_next = count_reg - 1'b1;
            if (below_low)
            begin
                low_next = PW'(top_idx);
            end
        end
        else if (ctl.push && !stat.full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= PW'(NODES);
            low_reg <= PW'(NODES);
        end
        else
        begin
            count_reg <= count_next;
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.pop && !stat.full)
        begin
            stack_mem[NW'(count_reg)] <= push_node;
        end
        rd_q <= stack_mem[top_idx];
    end

endmodule

// ===== rtl/chained_hash_table_unit.sv =====
// Chained hash table unit: insert, search and delete requests by key over a
// fixed pool of NODES records hashed into up to BUCKETS chains.
// Requests enter on the s_ stream (req_type, key, age) and each produces
// exactly one result item on the m_ stream (status, age_out).
// The bucket count is written over the APB port at address 0; write it only
// while no request is in flight.
// An item is accepted, then the remainder unit computes key modulo the
// bucket count (31 steps, then it hands over the remainder) and the chain head
// is read; a search or delete then walks the chain node by node, visiting at
// most NODES nodes, and finally the result is loaded into the output register.
// s_tready is low from the acceptance of an item until its result is loaded
// into the output register.
// The output register holds a finished result while the receiver stalls; the
// next item may be accepted meanwhile, but its result waits until the held
// one is taken.
// At reset all chains are empty, every node is free and the bucket count is
// ten; no clearing pass is needed.
module chained_hash_table_unit
#(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int NODES = cht_pkg::NODES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: req_type[1:0], key[32:2], age[40:33], zero fill.
    input  logic [cht_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: status[2:0], age_out[10:3], zero fill.
    output logic [cht_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cht_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [cht_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [cht_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NULL_NODE = PW'(NODES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_FIN = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [cht_pkg::NB_W-1:0]       nb_reg;
    logic [cht_pkg::NB_W-1:0]       nb_eff;
    logic [cht_pkg::REQ_W-1:0]      req_reg, req_next;
    logic [cht_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [cht_pkg::AGE_W-1:0]      age_reg, age_next;
    logic [BW-1:0]                  bucket_reg, bucket_next;
    logic [PW-1:0]                  prev_reg, prev_next;
    logic [NW-1:0]                  cur_reg, cur_next;
    logic [PW-1:0]                  steps_reg, steps_next;
    logic [PW-1:0]                  steps_inc;
    logic [cht_pkg::ST_W-1:0]       res_status;
    logic [cht_pkg::AGE_W-1:0]      res_age;
    logic [cht_pkg::ST_W-1:0]       status_reg, status_next;
    logic [cht_pkg::AGE_W-1:0]      age_out_reg, age_out_next;
    logic                           m_valid_reg, m_valid_next;
    logic [cht_pkg::ST_W-1:0]       m_status_reg, m_status_next;
    logic [cht_pkg::AGE_W-1:0]      m_age_reg, m_age_next;

    logic [PW-1:0]                  head_reg [BUCKETS];
    logic                           bh_we;
    logic [PW-1:0]                  bh_wdata;
    logic [PW-1:0]                  head;

    logic [cht_pkg::KEY_W-1:0]      key_mem [NODES];
    logic [cht_pkg::AGE_W-1:0]      age_mem [NODES];
    logic [PW-1:0]                  next_mem [NODES];
    logic                           node_we;
    logic [NW-1:0]                  node_waddr;
    logic                           nx_we;
    logic [NW-1:0]                  nx_waddr;
    logic [PW-1:0]                  nx_wdata;
    logic [NW-1:0]                  rd_addr;
    logic [cht_pkg::KEY_W-1:0]      key_q;
    logic [cht_pkg::AGE_W-1:0]      age_q;
    logic [PW-1:0]                  next_q;

    logic                           mod_start;
    logic                           mod_done;
    logic [cht_pkg::REM_W-1:0]      mod_rem;

    cht_pkg::free_ctl_t             free_ctl;
    cht_pkg::free_stat_t            free_stat;
    logic [NW-1:0]                  free_top;

    cht_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (key_next),
        .divisor  (nb_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    cht_free #(.NODES(NODES)) u_free
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (free_ctl),
        .push_node (cur_reg),
        .stat      (free_stat),
        .top_node  (free_top)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cht_pkg::REG_NUM_BUCKETS) ?
                    cht_pkg::CFG_DATA_W'(nb_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg <= cht_pkg::NB_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == cht_pkg::REG_NUM_BUCKETS)
        begin
            nb_reg <= pwdata[cht_pkg::NB_W-1:0];
        end
    end

    always_comb
    begin
        if (nb_reg == '0)
        begin
            nb_eff = cht_pkg::NB_W'(1);
        end
        else if (32'(nb_reg) > BUCKETS)
        begin
            nb_eff = cht_pkg::NB_W'(BUCKETS);
        end
        else
        begin
            nb_eff = nb_reg;
        end
    end

    assign head = head_reg[bucket_reg];
    assign steps_inc = steps_reg + 1'b1;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        key_next = key_reg;
        age_next = age_reg;
        bucket_next = bucket_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        status_next = status_reg;
        age_out_next = age_out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_age_next = m_age_reg;
        mod_start = 1'b0;
        free_ctl = '0;
        bh_we = 1'b0;
        bh_wdata = next_q;
        node_we = 1'b0;
        node_waddr = free_top;
        nx_we = 1'b0;
        nx_waddr = free_top;
        nx_wdata = head;
        rd_addr = NW'(head);
        res_status = cht_pkg::ST_NOT_FOUND;
        res_age = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next = s_tdata[1:0];
                    key_next = s_tdata[32:2];
                    age_next = s_tdata[40:33];
                    mod_start = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    bucket_next = BW'(mod_rem);
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                unique case (req_reg) inside
                    cht_pkg::REQ_INSERT:
                    begin
                        if (free_stat.empty)
                        begin
                            res_status = cht_pkg::ST_FULL;
                        end
                        else
                        begin
                            free_ctl.pop = 1'b1;
                            node_we = 1'b1;
                            nx_we = 1'b1;
                            bh_we = 1'b1;
                            bh_wdata = PW'(free_top);
                            res_status = cht_pkg::ST_INSERTED;
                        end
                        state_next = S_FIN;
                    end
                    cht_pkg::REQ_SEARCH, cht_pkg::REQ_DELETE:
                    begin
                        prev_next = NULL_NODE;
                        cur_next = NW'(head);
                        steps_next = '0;
                        state_next = (head >= NULL_NODE) ? S_FIN : S_WALK;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
                status_next = res_status;
                age_out_next = res_age;
            end
            S_WALK:
            begin
                rd_addr = NW'(next_q);
                if (key_q == key_reg)
                begin
                    if (req_reg == cht_pkg::REQ_SEARCH)
                    begin
                        res_status = cht_pkg::ST_FOUND;
                        res_age = age_q;
                    end
                    else
                    begin
                        if (prev_reg == NULL_NODE)
                        begin
                            bh_we = 1'b1;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            nx_waddr = NW'(prev_reg);
                            nx_wdata = next_q;
                        end
                        free_ctl.push = 1'b1;
                        res_status = cht_pkg::ST_DELETED;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next = steps_inc;
                    prev_next = PW'(cur_reg);
                    cur_next = NW'(next_q);
                    if (steps_inc >= NULL_NODE || next_q >= NULL_NODE)
                    begin
                        state_next = S_FIN;
                    end
                end
                status_next = res_status;
                age_out_next = res_age;
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_status_next = status_reg;
                    m_age_next = age_out_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_reg[i] <= NULL_NODE;
            end
        end
        else
        begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (bh_we)
            begin
                head_reg[bucket_reg] <= bh_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        key_reg <= key_next;
        age_reg <= age_next;
        bucket_reg <= bucket_next;
        prev_reg <= prev_next;
        cur_reg <= cur_next;
        steps_reg <= steps_next;
        status_reg <= status_next;
        age_out_reg <= age_out_next;
        m_status_reg <= m_status_next;
        m_age_reg <= m_age_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            key_mem[node_waddr] <= key_reg;
            age_mem[node_waddr] <= age_reg;
        end
        key_q <= key_mem[rd_addr];
        age_q <= age_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        next_q <= next_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {5'b0, m_age_reg, m_status_reg};

endmodule

// ===== rtl/cht_checker.sv =====
module cht_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cht_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // An accepted item keeps the block busy for at least the remainder pass.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after an item");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == cht_pkg::ST_INSERTED ||
                      m_tdata[2:0] == cht_pkg::ST_FOUND ||
                      m_tdata[2:0] == cht_pkg::ST_NOT_FOUND ||
                      m_tdata[2:0] == cht_pkg::ST_DELETED ||
                      m_tdata[2:0] == cht_pkg::ST_FULL))
        else $error("result status out of range");

    a_age_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != cht_pkg::ST_FOUND) |-> (m_tdata[10:3] == '0))
        else $error("age_out set on a result that is not found");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind chained_hash_table_unit cht_checker u_cht_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
